FILE: hdl/pic_pkg.sv
// Package for the vectored priority interrupt controller.
// Types, command and register codes, and reset constants shared by all pic modules.
`timescale 1ns / 1ps

package pic_pkg;

  localparam int unsigned PIC_NUM_LINES   = 32;
  localparam int unsigned PIC_NUM_VECTORS = 8;
  localparam int unsigned IRQ_W           = 32;
  localparam int unsigned LINE_W          = 5;   // width of the index of a line within irq_lines

  localparam logic [31:0] MASK_RESET   = 32'hffff_fff8;
  localparam logic [31:0] NONMASK_BITS = 32'h0000_0007;

  typedef enum logic [2:0] {
    CMD_READ    = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_REPORT  = 3'd2,
    CMD_SPECIAL = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    TRAP_NORMAL = 2'd0,
    TRAP_POWER  = 2'd1,
    TRAP_DSP    = 2'd2,
    TRAP_BRKPT  = 2'd3
  } trap_e;

  typedef enum logic [1:0] {
    SVC_NONE   = 2'd0,
    SVC_POWER  = 2'd1,
    SVC_BREAK  = 2'd2,
    SVC_NORMAL = 2'd3
  } svc_e;

  // bus register map
  localparam logic [5:0] REG_SW        = 6'd0;
  localparam logic [5:0] REG_SW2       = 6'd1;
  localparam logic [5:0] REG_MASK      = 6'd2;
  localparam logic [5:0] REG_ENABLE    = 6'd3;
  localparam logic [5:0] REG_PREV      = 6'd4;
  localparam logic [5:0] REG_CURRENT   = 6'd5;
  localparam logic [5:0] REG_PENDING   = 6'd6;
  localparam logic [5:0] REG_CAUSE     = 6'd7;
  localparam logic [5:0] REG_VEC_BASE  = 6'd8;
  localparam logic [5:0] REG_PRIO_BASE = 6'd16;
  localparam logic [5:0] REG_PRIO_END  = 6'd48;

  // configuration port indexes
  localparam logic CFG_CORE_INSTANCE = 1'b0;
  localparam logic CFG_RESET_VECTOR  = 1'b1;

  localparam logic [1:0] SIG_NONE    = 2'd0;
  localparam logic [1:0] SIG_THREAD0 = 2'd1;
  localparam logic [1:0] SIG_THREAD1 = 2'd2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [5:0]  reg_index;
    logic [31:0] write_data;
    logic [31:0] irq_lines;
    logic [1:0]  trap_kind;
  } pic_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        taken;
    logic [31:0] target_pc;
    logic [1:0]  signal_thread;
  } pic_out_t;

  // encoder result handed to the core
  typedef struct packed {
    logic [IRQ_W-1:0]  irq;       // lines beyond the configured count cleared
    logic [LINE_W-1:0] top_line;  // highest set line, 0 when none set
  } pic_enc_t;

endpackage

FILE: hdl/pic_prienc.sv
// Line qualifier and priority encoder for the interrupt controller.
// Depends on pic_pkg.
`timescale 1ns / 1ps

module pic_prienc import pic_pkg::*; #(
  parameter int unsigned NUM_LINES = PIC_NUM_LINES
) (
  input  logic [IRQ_W-1:0] irq_i,
  output pic_enc_t         enc_o
);

  logic [IRQ_W-1:0]  irq_m;
  logic [LINE_W-1:0] top;

  always_comb begin
    for (int i = 0; i < IRQ_W; i++) begin
      irq_m[i] = irq_i[i] & (i < NUM_LINES);
    end
  end

  // ascending scan, highest set line wins
  always_comb begin
    top = '0;
    for (int i = 0; i < IRQ_W; i++) begin
      if (irq_m[i]) begin
        top = LINE_W'(i);
      end
    end
  end

  assign enc_o.irq      = irq_m;
  assign enc_o.top_line = top;

endmodule

FILE: hdl/pic_core.sv
// Controller state, tables and command execution for one item per cycle while fire_i is high.
// Depends on pic_pkg; fed by pic_prienc.
`timescale 1ns / 1ps

module pic_core import pic_pkg::*; #(
  parameter int unsigned NUM_LINES   = PIC_NUM_LINES,
  parameter int unsigned NUM_VECTORS = PIC_NUM_VECTORS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  pic_in_t     item_i,
  input  pic_enc_t    enc_i,
  input  logic        core_instance_i,
  input  logic [31:0] reset_vector_i,
  output pic_out_t    result_o
);

  localparam int unsigned PRIO_DEPTH = (NUM_LINES < IRQ_W) ? NUM_LINES : IRQ_W;
  localparam int unsigned PRIO_AW    = $clog2(PRIO_DEPTH);
  localparam int unsigned VEC_AW     = $clog2(NUM_VECTORS);

  logic [31:0] mask_q, mask_d;
  logic [31:0] enable_q, enable_d;
  logic [2:0]  cur_q, cur_d;
  logic [31:0] prev_q, prev_d;
  logic [31:0] cause_q, cause_d;
  logic [31:0] sw_q, sw_d;
  logic [31:0] sw2_q, sw2_d;
  logic [1:0]  svc_q, svc_d;
  logic [31:0] vec_q  [NUM_VECTORS];
  logic [2:0]  prio_q [PRIO_DEPTH];

  logic        is_read, is_write, is_report, is_special, is_clear;
  logic [5:0]  r;
  logic [31:0] wd;
  logic [31:0] irq;
  logic [1:0]  kind;
  logic        in_prio_range, in_vec_range;
  logic [4:0]  prio_off;
  logic [4:0]  prio_addr;
  logic [2:0]  prio_rd;
  logic [VEC_AW-1:0] vec_addr;
  logic [31:0] vec_rd;
  logic        enabled;
  logic        vec_we, prio_we;
  logic [31:0] rd;
  logic        tk;
  logic [31:0] pc;
  logic [1:0]  sig;

  assign r    = item_i.reg_index;
  assign wd   = item_i.write_data;
  assign irq  = enc_i.irq;
  assign kind = item_i.trap_kind;

  assign is_read    = (item_i.cmd == CMD_READ);
  assign is_write   = (item_i.cmd == CMD_WRITE);
  assign is_report  = (item_i.cmd == CMD_REPORT);
  assign is_special = (item_i.cmd == CMD_SPECIAL);
  assign is_clear   = (item_i.cmd == CMD_CLEAR);

  assign in_vec_range  = (r >= REG_VEC_BASE) && (r < REG_PRIO_BASE);
  assign in_prio_range = (r >= REG_PRIO_BASE) && (r < REG_PRIO_END);
  assign prio_off      = 5'(r - REG_PRIO_BASE);

  // one read port per table: the bus index on a read, else the top line (vector: level or 7)
  assign prio_addr = is_read ? prio_off : enc_i.top_line;
  assign prio_rd   = ({1'b0, prio_addr} < 6'(PRIO_DEPTH)) ? prio_q[prio_addr[PRIO_AW-1:0]]
                                                          : 3'd0;

  always_comb begin
    if (is_read) begin
      vec_addr = VEC_AW'(r - REG_VEC_BASE);
    end else if (is_report && (kind == TRAP_DSP)) begin
      vec_addr = VEC_AW'(NUM_VECTORS - 1);
    end else begin
      vec_addr = prio_rd[VEC_AW-1:0];
    end
  end
  assign vec_rd = vec_q[vec_addr];

  // lines 0..2 are never masked
  assign enabled = (|(irq & NONMASK_BITS)) || ((enable_q != '0) && (|(~mask_q & irq)));

  always_comb begin
    mask_d   = mask_q;
    enable_d = enable_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    cause_d  = cause_q;
    sw_d     = sw_q;
    sw2_d    = sw2_q;
    svc_d    = svc_q;
    vec_we   = 1'b0;
    prio_we  = 1'b0;
    rd       = '0;
    tk       = 1'b0;
    pc       = '0;
    sig      = SIG_NONE;

    if (is_read) begin
      priority if (r == REG_SW)      rd = sw_q;
      else if (r == REG_SW2)         rd = sw2_q;
      else if (r == REG_MASK)        rd = mask_q;
      else if (r == REG_ENABLE)      rd = enable_q;
      else if (r == REG_PREV)        rd = prev_q;
      else if (r == REG_CURRENT)     rd = {29'd0, cur_q};
      else if (r == REG_PENDING)     rd = '0;
      else if (r == REG_CAUSE)       rd = cause_q;
      else if (in_vec_range)         rd = vec_rd;
      else if (in_prio_range)        rd = {29'd0, prio_rd};
      else                           rd = '0;
    end else if (is_write) begin
      priority if (r == REG_SW) begin
        sw_d = wd;
        sig  = core_instance_i ? SIG_THREAD1 : SIG_THREAD0;
      end else if (r == REG_SW2) begin
        sw2_d = wd;
      end else if (r == REG_MASK) begin
        mask_d = wd & ~NONMASK_BITS;
      end else if (r == REG_ENABLE) begin
        enable_d = wd;
      end else if (r == REG_PREV) begin
        prev_d = wd;
      end else if (in_vec_range) begin
        vec_we = 1'b1;
      end else if (in_prio_range) begin
        prio_we = ({1'b0, prio_off} < 6'(PRIO_DEPTH));
      end else begin
        // current, pending, cause and unused indexes ignore writes
      end
    end else if (is_report && (kind == TRAP_POWER)) begin
      svc_d = SVC_POWER;
      pc    = reset_vector_i;
      tk    = 1'b1;
    end else if (is_report && (kind == TRAP_DSP)) begin
      svc_d   = SVC_BREAK;
      prev_d  = {29'd0, cur_q};
      cur_d   = 3'd7;
      cause_d = irq;
      pc      = vec_rd;
      tk      = 1'b1;
    end else if (is_report && (kind == TRAP_BRKPT)) begin
      svc_d   = SVC_BREAK;
      cause_d = irq;
      pc      = vec_rd;
      tk      = 1'b1;
    end else if ((is_report && enabled && (svc_q != SVC_BREAK) && (cur_q <= prio_rd)) ||
                 (is_special && enabled)) begin
      cause_d  = irq;
      svc_d    = SVC_NORMAL;
      prev_d   = {27'd0, enable_q[0], 1'b0, cur_q};
      cur_d    = prio_rd;
      enable_d = '0;
      pc       = vec_rd;
      tk       = 1'b1;
    end else if (is_clear) begin
      svc_d = SVC_NONE;
      if (svc_q != SVC_BREAK) begin
        enable_d = {31'd0, prev_q[4]};
        cur_d    = prev_q[2:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= MASK_RESET;
      enable_q <= '0;
      cur_q    <= '0;
      prev_q   <= '0;
      cause_q  <= '0;
      sw_q     <= '0;
      sw2_q    <= '0;
      svc_q    <= SVC_NONE;
      for (int i = 0; i < NUM_VECTORS; i++) begin
        vec_q[i] <= '0;
      end
      for (int i = 0; i < PRIO_DEPTH; i++) begin
        prio_q[i] <= '0;
      end
    end else if (fire_i) begin
      mask_q   <= mask_d;
      enable_q <= enable_d;
      cur_q    <= cur_d;
      prev_q   <= prev_d;
      cause_q  <= cause_d;
      sw_q     <= sw_d;
      sw2_q    <= sw2_d;
      svc_q    <= svc_d;
      if (vec_we) begin
        vec_q[VEC_AW'(r - REG_VEC_BASE)] <= wd;
      end
      if (prio_we) begin
        prio_q[prio_off[PRIO_AW-1:0]] <= wd[2:0];
      end
    end
  end

  assign result_o.read_data     = rd;
  assign result_o.taken         = tk;
  assign result_o.target_pc     = pc;
  assign result_o.signal_thread = sig;

  // an accepted normal or special report always drops the global enable
  a_take_clears_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && tk && (is_special || (is_report && (kind == TRAP_NORMAL)))
    |=> (enable_q == '0))
    else $error("enable still set after an accepted interrupt");

  a_dsp_sets_break: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && is_report && (kind == TRAP_DSP)
    |=> (cur_q == 3'd7) && (svc_q == SVC_BREAK))
    else $error("dsp reset did not enter break service at level 7");

  a_taken_only_on_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && tk |-> (is_report || is_special))
    else $error("taken raised for a non-report item");

  a_signal_only_on_sw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (sig != SIG_NONE) |-> (is_write && (r == REG_SW)))
    else $error("thread signal without a software interrupt write");

  a_mask_low_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && is_write && (r == REG_MASK) |=> (mask_q[2:0] == 3'd0))
    else $error("non-maskable bits stored in mask");

endmodule

FILE: hdl/priority_interrupt_controller_top.sv
// Top level of the vectored priority interrupt controller.
// Depends on pic_pkg, pic_prienc and pic_core.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one command item:
//   bus read, bus write, interrupt report, special report or clear.
//   Output channel (out_valid_o / out_stall_i / out_data_o) returns exactly one
//   result item for every input item, in order.
//   From input acceptance an item waits in the input register, then the
//   encoder, table reads and state update run in a single pass into the
//   result register.
//   Throughput is one item per cycle while the receiver does not stall; the state update of one item is visible
//   to the next item with no bubble.
//   When the receiver stalls, the result register holds its item; the input
//   register keeps filling, and in_stall_o rises once both are full.
//   Reset clears all state to its reset values (mask 0xfffffff8, everything
//   else zero) at once; items are accepted from the first cycle after reset.
//   cfg_we_i writes core_instance (index 0) or reset_vector (index 1); write
//   only while no item is in flight.
module priority_interrupt_controller_top import pic_pkg::*; #(
  parameter int unsigned NUM_LINES   = PIC_NUM_LINES,
  parameter int unsigned NUM_VECTORS = PIC_NUM_VECTORS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  pic_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output pic_out_t    out_data_o
);

  logic        core_instance_q;
  logic [31:0] reset_vector_q;
  logic        in_valid_q;
  pic_in_t     in_q;
  logic        out_valid_q;
  pic_out_t    out_q;
  logic        fire;
  pic_enc_t    enc;
  pic_out_t    result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_instance_q <= 1'b0;
      reset_vector_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CORE_INSTANCE: core_instance_q <= cfg_data_i[0];
        CFG_RESET_VECTOR:  reset_vector_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item leaves the input register when the result register is free or draining
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  pic_prienc #(
    .NUM_LINES (NUM_LINES)
  ) u_prienc (
    .irq_i (in_q.irq_lines),
    .enc_o (enc)
  );

  pic_core #(
    .NUM_LINES   (NUM_LINES),
    .NUM_VECTORS (NUM_VECTORS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .item_i          (in_q),
    .enc_i           (enc),
    .core_instance_i (core_instance_q),
    .reset_vector_i  (reset_vector_q),
    .result_o        (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for priority_interrupt_controller_top: directed and random command items.
// Checks each result against an in-bench model of the controller; depends on pic_pkg and the top level.
`timescale 1ns / 1ps

module tb_top;
  import pic_pkg::*;

  localparam int          CYCLE_LIMIT    = 400000;
  localparam int          PHASE_ITEMS    = 285;
  localparam int          NUM_SETTINGS   = 5;
  localparam int          MAX_PRINTED    = 50;
  localparam logic [5:0]  REG_UNUSED_TOP = 6'd63;
  localparam logic [2:0]  CMD_UNUSED_LO  = 3'd5;
  localparam logic [2:0]  CMD_UNUSED_HI  = 3'd7;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  pic_in_t     in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  pic_out_t    out_data_o;

  priority_interrupt_controller_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the controller state and its two settings
  logic        sh_core_sel;
  logic [31:0] sh_reset_pc;
  logic [31:0] sh_mask;
  logic [31:0] sh_enable;
  logic [2:0]  sh_level;
  logic [31:0] sh_prev;
  logic [31:0] sh_cause;
  logic [31:0] sh_soft;
  logic [31:0] sh_soft2;
  svc_e        sh_svc;
  logic [31:0] sh_vec [PIC_NUM_VECTORS];
  logic [2:0]  sh_prio [PIC_NUM_LINES];

  pic_in_t  pending_items [$];
  pic_out_t expected_results [$];

  int items_queued    = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int taken_count     = 0;
  int mismatch_count  = 0;
  int cycle_count     = 0;

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_PRINTED)
      $display("tb_top: mismatch at result %0d: %s", results_checked, msg);
    mismatch_count++;
  endtask

  // acceptance of a normal or special report
  function automatic logic [31:0] take_interrupt(logic [31:0] lines, logic [2:0] lvl);
    sh_cause  = lines;
    sh_svc    = SVC_NORMAL;
    sh_prev   = {27'b0, sh_enable[0], 1'b0, sh_level};
    sh_level  = lvl;
    sh_enable = '0;
    return sh_vec[lvl];
  endfunction

  function automatic pic_out_t predict_result(pic_in_t it);
    pic_out_t   res;
    logic [4:0] hi_line;
    logic [2:0] lvl;
    logic       lines_ok;
    logic [5:0] idx;
    res     = '0;
    idx     = it.reg_index;
    hi_line = '0;
    for (int i = 0; i < PIC_NUM_LINES; i++)
      if (it.irq_lines[i]) hi_line = i[4:0];
    lvl = sh_prio[hi_line];
    // non-maskable lines always pass; others need the global enable and a clear mask bit
    lines_ok = ((it.irq_lines & NONMASK_BITS) != 0) ||
               ((sh_enable != 0) && ((~sh_mask & it.irq_lines) != 0));
    case (it.cmd)
      CMD_READ: begin
        case (idx)
          REG_SW:      res.read_data = sh_soft;
          REG_SW2:     res.read_data = sh_soft2;
          REG_MASK:    res.read_data = sh_mask;
          REG_ENABLE:  res.read_data = sh_enable;
          REG_PREV:    res.read_data = sh_prev;
          REG_CURRENT: res.read_data = {29'b0, sh_level};
          REG_PENDING: res.read_data = '0;
          REG_CAUSE:   res.read_data = sh_cause;
          default: begin
            if (idx >= REG_VEC_BASE && idx < REG_PRIO_BASE)
              res.read_data = sh_vec[idx[2:0]];
            else if (idx >= REG_PRIO_BASE && idx < REG_PRIO_END)
              res.read_data = {29'b0, sh_prio[idx - REG_PRIO_BASE]};
          end
        endcase
      end
      CMD_WRITE: begin
        case (idx)
          REG_SW: begin
            sh_soft = it.write_data;
            res.signal_thread = sh_core_sel ? SIG_THREAD1 : SIG_THREAD0;
          end
          REG_SW2:    sh_soft2  = it.write_data;
          REG_MASK:   sh_mask   = it.write_data & ~NONMASK_BITS;
          REG_ENABLE: sh_enable = it.write_data;
          REG_PREV:   sh_prev   = it.write_data;
          default: begin
            if (idx >= REG_VEC_BASE && idx < REG_PRIO_BASE)
              sh_vec[idx[2:0]] = it.write_data;
            else if (idx >= REG_PRIO_BASE && idx < REG_PRIO_END)
              sh_prio[idx - REG_PRIO_BASE] = it.write_data[2:0];
          end
        endcase
      end
      CMD_REPORT: begin
        case (it.trap_kind)
          TRAP_POWER: begin
            sh_svc        = SVC_POWER;
            res.target_pc = sh_reset_pc;
            res.taken     = 1'b1;
          end
          TRAP_DSP: begin
            sh_svc        = SVC_BREAK;
            sh_prev       = {29'b0, sh_level};
            sh_level      = 3'd7;
            sh_cause      = it.irq_lines;
            res.target_pc = sh_vec[3'd7];
            res.taken     = 1'b1;
          end
          TRAP_BRKPT: begin
            sh_svc        = SVC_BREAK;
            sh_cause      = it.irq_lines;
            res.target_pc = sh_vec[lvl];
            res.taken     = 1'b1;
          end
          default: begin
            if (lines_ok && sh_svc != SVC_BREAK && sh_level <= lvl) begin
              res.target_pc = take_interrupt(it.irq_lines, lvl);
              res.taken     = 1'b1;
            end
          end
        endcase
      end
      CMD_SPECIAL: begin
        if (lines_ok) begin
          res.target_pc = take_interrupt(it.irq_lines, lvl);
          res.taken     = 1'b1;
        end
      end
      CMD_CLEAR: begin
        // a clear during break service only ends the break
        if (sh_svc != SVC_BREAK) begin
          sh_enable = {31'b0, sh_prev[4]};
          sh_level  = sh_prev[2:0];
        end
        sh_svc = SVC_NONE;
      end
      default: ;
    endcase
    return res;
  endfunction

  // sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(predict_result(in_data_i));
        items_sent++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_items.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: checks results and stalls on a pattern that changes mode now and then
  stall_e stall_mode = STALL_NONE;
  int     mode_left  = 0;
  int     stall_tick = 0;

  always @(posedge clk_i) begin : result_check
    pic_out_t got;
    pic_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = out_data_o;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (want.taken) taken_count++;
          if (got.read_data !== want.read_data)
            report_mismatch($sformatf("read_data %h, expected %h",
                                      got.read_data, want.read_data));
          if (got.taken !== want.taken)
            report_mismatch($sformatf("taken %b, expected %b", got.taken, want.taken));
          if (got.target_pc !== want.target_pc)
            report_mismatch($sformatf("target_pc %h, expected %h",
                                      got.target_pc, want.target_pc));
          if (got.signal_thread !== want.signal_thread)
            report_mismatch($sformatf("signal_thread %0d, expected %0d",
                                      got.signal_thread, want.signal_thread));
        end
        results_checked++;
      end
      stall_tick++;
      if (mode_left == 0) begin
        mode_left  = $urandom_range(20, 120);
        stall_mode = stall_e'($urandom_range(0, 3));
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:     out_stall_i <= ((stall_tick % 5) < 2);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic queue_item(logic [2:0] c, logic [5:0] idx, logic [31:0] wd,
                            logic [31:0] lines, trap_e tk);
    pic_in_t it;
    it.cmd        = c;
    it.reg_index  = idx;
    it.write_data = wd;
    it.irq_lines  = lines;
    it.trap_kind  = tk;
    pending_items.push_back(it);
    items_queued++;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'd1 << $urandom_range(0, 31);
      3:       return $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_lines();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return 32'd1 << $urandom_range(0, 31);
      4:       return $urandom_range(1, 7);
      5:       return $urandom & $urandom & ~NONMASK_BITS;
      default: return $urandom;
    endcase
  endfunction

  function automatic trap_e pick_trap();
    case ($urandom_range(0, 9))
      7:       return TRAP_POWER;
      8:       return TRAP_DSP;
      9:       return TRAP_BRKPT;
      default: return TRAP_NORMAL;
    endcase
  endfunction

  function automatic logic [5:0] pick_index();
    case ($urandom_range(0, 9))
      0:       return REG_ENABLE;
      1:       return REG_MASK;
      2:       return REG_PREV;
      3:       return $urandom_range(0, 1) ? REG_SW : REG_SW2;
      4, 5:    return REG_VEC_BASE + 6'($urandom_range(0, PIC_NUM_VECTORS - 1));
      6, 7:    return REG_PRIO_BASE + 6'($urandom_range(0, PIC_NUM_LINES - 1));
      default: return 6'($urandom_range(0, REG_UNUSED_TOP));
    endcase
  endfunction

  function automatic logic [2:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return CMD_READ;
    if (r < 55) return CMD_WRITE;
    if (r < 78) return CMD_REPORT;
    if (r < 86) return CMD_SPECIAL;
    if (r < 97) return CMD_CLEAR;
    return 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
  endfunction

  task automatic queue_random(int n);
    int target;
    target = items_queued + n;
    while (items_queued < target) begin
      if ($urandom_range(0, 9) < 4) begin
        // service sequence: arm, report (maybe nested), look at state, clear
        queue_item(CMD_WRITE, REG_ENABLE, ($urandom_range(0, 3) == 0) ? pick_word() : 32'd1,
                   pick_lines(), pick_trap());
        if ($urandom_range(0, 2) == 0)
          queue_item(CMD_WRITE, REG_MASK, pick_word(), pick_lines(), pick_trap());
        if ($urandom_range(0, 3) == 0)
          queue_item(CMD_WRITE, REG_PRIO_BASE + 6'($urandom_range(0, PIC_NUM_LINES - 1)),
                     pick_word(), pick_lines(), pick_trap());
        queue_item(($urandom_range(0, 4) == 0) ? CMD_SPECIAL : CMD_REPORT, pick_index(),
                   pick_word(), pick_lines(), pick_trap());
        if ($urandom_range(0, 1))
          queue_item(CMD_REPORT, pick_index(), pick_word(), pick_lines(), pick_trap());
        if ($urandom_range(0, 1))
          queue_item(CMD_READ, 6'($urandom_range(REG_SW, REG_CAUSE)), pick_word(),
                     pick_lines(), pick_trap());
        queue_item(CMD_CLEAR, pick_index(), pick_word(), pick_lines(), pick_trap());
      end else begin
        queue_item(pick_cmd(), pick_index(), pick_word(), pick_lines(), pick_trap());
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(logic idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_CORE_INSTANCE) sh_core_sel = val[0];
    else sh_reset_pc = val;
  endtask

  initial begin
    sh_core_sel = 1'b0;
    sh_reset_pc = '0;
    sh_mask     = MASK_RESET;
    sh_enable   = '0;
    sh_level    = '0;
    sh_prev     = '0;
    sh_cause    = '0;
    sh_soft     = '0;
    sh_soft2    = '0;
    sh_svc      = SVC_NONE;
    foreach (sh_vec[i]) sh_vec[i] = '0;
    foreach (sh_prio[i]) sh_prio[i] = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, with the settings left at their reset values
    queue_item(CMD_READ, REG_MASK, '0, '0, TRAP_NORMAL);
    queue_item(CMD_READ, REG_PENDING, '0, '0, TRAP_NORMAL);
    queue_item(CMD_READ, REG_UNUSED_TOP, '1, '1, TRAP_BRKPT);
    queue_item(CMD_WRITE, REG_MASK, '1, '0, TRAP_NORMAL);
    queue_item(CMD_READ, REG_MASK, '0, '0, TRAP_NORMAL);
    queue_item(CMD_WRITE, REG_PRIO_BASE, '1, '0, TRAP_NORMAL);
    queue_item(CMD_WRITE, REG_PRIO_END - 6'd1, 32'd5, '0, TRAP_NORMAL);
    queue_item(CMD_WRITE, REG_CURRENT, '1, '0, TRAP_NORMAL);
    queue_item(CMD_WRITE, REG_CAUSE, '1, '0, TRAP_NORMAL);
    queue_item(CMD_WRITE, REG_UNUSED_TOP, '1, '0, TRAP_NORMAL);
    queue_item(CMD_WRITE, REG_SW, '1, '0, TRAP_NORMAL);
    queue_item(CMD_WRITE, REG_VEC_BASE + 6'd7, 32'h8000_0004, '0, TRAP_NORMAL);
    queue_item(CMD_REPORT, REG_SW, '0, '0, TRAP_NORMAL);           // no line set
    queue_item(CMD_REPORT, REG_SW, '0, 32'd1, TRAP_NORMAL);        // non-maskable line
    queue_item(CMD_CLEAR, REG_SW, '0, '0, TRAP_NORMAL);
    queue_item(CMD_WRITE, REG_ENABLE, 32'd1, '0, TRAP_NORMAL);
    queue_item(CMD_WRITE, REG_MASK, '0, '0, TRAP_NORMAL);
    queue_item(CMD_REPORT, REG_SW, '0, 32'h8000_0000, TRAP_NORMAL);
    queue_item(CMD_SPECIAL, REG_SW, '0, '1, TRAP_NORMAL);
    queue_item(CMD_REPORT, REG_SW, '0, '0, TRAP_POWER);
    queue_item(CMD_REPORT, REG_SW, '0, 32'ha5a5_0000, TRAP_DSP);
    queue_item(CMD_REPORT, REG_SW, '0, 32'h8000_0000, TRAP_BRKPT);
    queue_item(CMD_CLEAR, REG_SW, '0, '0, TRAP_NORMAL);            // ends the break only
    queue_item(CMD_UNUSED_HI, REG_SW, '1, '1, TRAP_DSP);
    queue_item(CMD_READ, REG_CAUSE, '0, '0, TRAP_NORMAL);
    queue_random(PHASE_ITEMS);
    wait_idle();

    for (int p = 0; p < NUM_SETTINGS - 1; p++) begin
      set_config(CFG_CORE_INSTANCE, (p % 2 == 0) ? 32'd1 : 32'd0);
      set_config(CFG_RESET_VECTOR, (p == 0) ? 32'hffff_ffff : (p == 1) ? 32'd0 : $urandom);
      queue_random(PHASE_ITEMS);
      wait_idle();
    end

    $display("tb_top: %0d items over %0d settings, %0d results checked (%0d taken)",
             items_sent, NUM_SETTINGS, results_checked, taken_count);
    $display("tb_top: %0d mismatches in %0d cycles", mismatch_count, cycle_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
